// File: design/assert_macros.svh
// Assertion macros used by the lane sampler checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LPPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define LPPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lpps_pkg.sv
// Package: shared types, register codes and fixed-point helpers of the lane sampler.
package lpps_pkg;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_LOWER_LIMIT  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_FRAME_WIDTH  = 2'd2
  } reg_index_t;

  localparam logic [15:0] LOWER_LIMIT_RST  = 16'd0;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd360;
  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;

  localparam logic signed [24:0] ONE_Q16 = 25'sd65536;
  localparam logic signed [33:0] Q24_MAX = 34'sd8388607;
  localparam logic signed [33:0] Q24_MIN = -34'sd8388608;
  localparam logic signed [26:0] Y_MAX   = 27'sd65536;
  localparam logic signed [25:0] X_MAX   = 26'sd524287;
  localparam logic signed [25:0] X_MIN   = -26'sd524288;

  // One sample point request into the point pipeline
  typedef struct packed {
    logic               valid;
    logic [5:0]         idx;
    logic               last;
    logic signed [24:0] t;
    logic signed [23:0] c3;
    logic signed [23:0] c2;
    logic signed [23:0] c1;
    logic signed [23:0] c0;
  } point_req_t;

  // One finished sample point
  typedef struct packed {
    logic               valid;
    logic [5:0]         idx;
    logic               last;
    logic [16:0]        y;
    logic signed [19:0] x;
  } point_res_t;

  // Horner step: round(m / 2^16) + c, clamped to signed Q7.16
  function automatic logic signed [23:0] horner_step(input logic signed [48:0] m,
                                                     input logic signed [23:0] c);
    logic signed [48:0] biased;
    logic signed [33:0] sum;
    begin
      biased = m + 49'sd32768;
      sum    = 34'(signed'(biased[48:16])) + 34'(c);
      if (sum > Q24_MAX) begin
        horner_step = 24'(Q24_MAX);
      end else if (sum < Q24_MIN) begin
        horner_step = 24'(Q24_MIN);
      end else begin
        horner_step = sum[23:0];
      end
    end
  endfunction

endpackage

// File: design/lpps_point_pipe.sv
// Point pipeline: Horner cubic and pixel scaling, one point per cycle, eight stages.
module lpps_point_pipe import lpps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  point_req_t  req,
  input  logic [12:0] frame_height,
  input  logic [12:0] frame_width,
  output point_res_t  res
);

  // Per-stage valid bits
  logic [7:0] vld;

  // Stage payloads
  logic [5:0]         idx   [8];
  logic               last  [8];
  logic signed [24:0] t1, t2, t3, t4;
  logic signed [23:0] c2_1, c1_1, c1_2, c1_3, c0_1, c0_2, c0_3, c0_4, c0_5;
  logic signed [48:0] m1, m3, m5;
  logic signed [38:0] yp1;
  logic signed [23:0] p2, p4, p6;
  logic signed [37:0] mx7;
  logic [16:0]        y   [2:8];
  logic signed [19:0] x8;

  // Combinational rounding of the pixel scalings
  logic signed [38:0] y_biased;
  logic signed [26:0] y_round;
  logic [16:0]        y_clamped;
  logic signed [37:0] x_biased;
  logic signed [25:0] x_round;
  logic signed [19:0] x_clamped;

  always_comb begin
    y_biased = yp1 + 39'sd2048;
    y_round  = y_biased[38:12];
    if (y_round < 27'sd0) begin
      y_clamped = '0;
    end else if (y_round > Y_MAX) begin
      y_clamped = 17'(Y_MAX);
    end else begin
      y_clamped = y_round[16:0];
    end
    x_biased = mx7 + 38'sd2048;
    x_round  = x_biased[37:12];
    if (x_round > X_MAX) begin
      x_clamped = 20'(X_MAX);
    end else if (x_round < X_MIN) begin
      x_clamped = 20'(X_MIN);
    end else begin
      x_clamped = x_round[19:0];
    end
  end

  // Valid bits move every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:0], req.valid};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    // stage 1: first Horner product and y product
    idx[0] <= req.idx;  last[0] <= req.last;
    m1   <= req.c3 * req.t;
    yp1  <= req.t * $signed({1'b0, frame_height});
    t1   <= req.t;
    c2_1 <= req.c2;  c1_1 <= req.c1;  c0_1 <= req.c0;
    // stage 2: add c2, round y
    idx[1] <= idx[0];  last[1] <= last[0];
    p2   <= horner_step(m1, c2_1);
    y[2] <= y_clamped;
    t2   <= t1;  c1_2 <= c1_1;  c0_2 <= c0_1;
    // stage 3: second product
    idx[2] <= idx[1];  last[2] <= last[1];
    m3   <= p2 * t2;
    y[3] <= y[2];
    t3   <= t2;  c1_3 <= c1_2;  c0_3 <= c0_2;
    // stage 4: add c1
    idx[3] <= idx[2];  last[3] <= last[2];
    p4   <= horner_step(m3, c1_3);
    y[4] <= y[3];
    t4   <= t3;  c0_4 <= c0_3;
    // stage 5: third product
    idx[4] <= idx[3];  last[4] <= last[3];
    m5   <= p4 * t4;
    y[5] <= y[4];
    c0_5 <= c0_4;
    // stage 6: add c0
    idx[5] <= idx[4];  last[5] <= last[4];
    p6   <= horner_step(m5, c0_5);
    y[6] <= y[5];
    // stage 7: scale by width
    idx[6] <= idx[5];  last[6] <= last[5];
    mx7  <= p6 * $signed({1'b0, frame_width});
    y[7] <= y[6];
    // stage 8: round and clamp x
    idx[7] <= idx[6];  last[7] <= last[6];
    x8   <= x_clamped;
    y[8] <= y[7];
  end

  assign res.valid = vld[7];
  assign res.idx   = idx[7];
  assign res.last  = last[7];
  assign res.y     = y[8];
  assign res.x     = x8;

endmodule

// File: design/lane_polynomial_point_sampler_unit.sv
// Lane sampler: a request is accepted at 2 setup stages, a point sequencer, then 8 point stages.
// Path: setup stage 1, setup stage 2 (may wait on the sequencer), sequencer, point stages.
// Throughput: one point per cycle while a lane runs; setup stages take the next lane meanwhile.
// A rejected lane is dropped at the accepting edge.
// Reset (synchronous rst) empties all stages; registers return to 0, 360 and 640.
module lane_polynomial_point_sampler_unit import lpps_pkg::*; #(
  parameter int POINT_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] confidence_logit,
  input  logic signed [23:0] lower_end,
  input  logic signed [23:0] upper_end,
  input  logic signed [23:0] coef_cubic,
  input  logic signed [23:0] coef_square,
  input  logic signed [23:0] coef_linear,
  input  logic signed [23:0] coef_const,
  // result channel
  output logic               result_valid,
  output logic [5:0]         point_index,
  output logic [16:0]        y_position,
  output logic signed [19:0] x_position,
  output logic               last_point,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int          IDX_W      = $clog2(POINT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINT_COUNT - 1);
  // slice = |span| / POINT_COUNT by reciprocal multiply, exact for 24-bit spans
  localparam int          DIV_SHIFT  = 31;
  localparam logic [31:0] DIV_RECIP  =
    32'(((64'd1 << DIV_SHIFT) + 64'(POINT_COUNT) - 64'd1) / 64'(POINT_COUNT));

  // Configuration registers
  logic [15:0] lower_limit;
  logic [12:0] frame_height;
  logic [12:0] frame_width;
  reg_index_t  reg_sel;
  logic        reg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limit  <= LOWER_LIMIT_RST;
      frame_height <= FRAME_HEIGHT_RST;
      frame_width  <= FRAME_WIDTH_RST;
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_LOWER_LIMIT:  lower_limit  <= pwdata[15:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[12:0];
        REG_FRAME_WIDTH:  frame_width  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LOWER_LIMIT:  prdata = {16'd0, lower_limit};
      REG_FRAME_HEIGHT: prdata = {19'd0, frame_height};
      REG_FRAME_WIDTH:  prdata = {19'd0, frame_width};
      default:          prdata = '0;
    endcase
  end

  // Lane screening and span at the request
  logic signed [24:0] llim_s, lo_s, up_s, lower_c, upper_c, span;
  logic               kept;

  always_comb begin
    llim_s  = signed'({9'd0, lower_limit});
    lo_s    = 25'(lower_end);
    up_s    = 25'(upper_end);
    kept    = (confidence_logit > 24'sd0) && (up_s > llim_s);
    lower_c = (lo_s > llim_s) ? lo_s : llim_s;
    upper_c = (up_s < ONE_Q16) ? up_s : ONE_Q16;
    span    = upper_c - lower_c;
  end

  // Setup stage 1 and 2 registers
  logic               s1_valid, s2_valid;
  logic signed [24:0] s1_lower, s2_lower;
  logic [23:0]        s1_mag;
  logic               s1_neg, s2_neg;
  logic [55:0]        s2_prod;
  logic signed [23:0] s1_c3, s1_c2, s1_c1, s1_c0;
  logic signed [23:0] s2_c3, s2_c2, s2_c1, s2_c0;

  // Point sequencer registers
  logic               gen_active;
  logic [IDX_W-1:0]   gen_idx;
  logic signed [24:0] gen_t, gen_slice;
  logic signed [23:0] gen_c3, gen_c2, gen_c1, gen_c0;

  logic gen_last, gen_load, s2_adv, s1_adv, accept;
  logic signed [24:0] slice_load;

  // Handoff: a stage moves when the one ahead is empty or moving
  always_comb begin
    gen_last   = gen_active && (gen_idx == LAST_IDX);
    gen_load   = s2_valid && (!gen_active || gen_last);
    s2_adv     = !s2_valid || gen_load;
    s1_adv     = !s1_valid || s2_adv;
    busy       = !s1_adv;
    accept     = start && s1_adv;
    slice_load = s2_neg ? -signed'({1'b0, s2_prod[DIV_SHIFT +: 24]})
                        :  signed'({1'b0, s2_prod[DIV_SHIFT +: 24]});
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      gen_active <= 1'b0;
      gen_idx    <= '0;
    end else begin
      if (s1_adv) begin
        s1_valid <= accept && kept;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
      if (gen_load) begin
        gen_active <= 1'b1;
        gen_idx    <= '0;
      end else if (gen_last) begin
        gen_active <= 1'b0;
      end else if (gen_active) begin
        gen_idx <= gen_idx + 1'b1;
      end
    end
  end

  // Setup and sequencer payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_lower <= lower_c;
      s1_neg   <= span[24];
      s1_mag   <= span[24] ? 24'(-span) : span[23:0];
      s1_c3    <= coef_cubic;
      s1_c2    <= coef_square;
      s1_c1    <= coef_linear;
      s1_c0    <= coef_const;
    end
    if (s2_adv) begin
      s2_lower <= s1_lower;
      s2_neg   <= s1_neg;
      s2_prod  <= 56'(s1_mag) * 56'(DIV_RECIP);
      s2_c3    <= s1_c3;
      s2_c2    <= s1_c2;
      s2_c1    <= s1_c1;
      s2_c0    <= s1_c0;
    end
    if (gen_load) begin
      gen_t     <= s2_lower;
      gen_slice <= slice_load;
      gen_c3    <= s2_c3;
      gen_c2    <= s2_c2;
      gen_c1    <= s2_c1;
      gen_c0    <= s2_c0;
    end else if (gen_active) begin
      gen_t <= gen_t + gen_slice;
    end
  end

  // Point pipeline
  point_req_t req;
  point_res_t res;

  always_comb begin
    req.valid = gen_active;
    req.idx   = 6'(gen_idx);
    req.last  = gen_last;
    req.t     = gen_t;
    req.c3    = gen_c3;
    req.c2    = gen_c2;
    req.c1    = gen_c1;
    req.c0    = gen_c0;
  end

  lpps_point_pipe u_point_pipe (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .frame_height (frame_height),
    .frame_width  (frame_width),
    .res          (res)
  );

  assign result_valid = res.valid;
  assign point_index  = res.idx;
  assign last_point   = res.last;
  assign y_position   = res.y;
  assign x_position   = res.x;

endmodule

// File: design/lpps_checker.sv
// Port checker of the lane sampler and its bind to the top level.
`include "assert_macros.svh"

module lpps_checker #(
  parameter int POINT_COUNT = 16
) (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       result_valid,
  input logic [5:0] point_index,
  input logic       last_point
);

  // after reset nothing is pending and nothing is strobed
  `LPPS_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !busy && !result_valid, "not empty after reset")

  // points of one lane come in consecutive cycles with rising index
  `LPPS_ASSERT_NEXT(a_points_run, clk, rst, result_valid && !last_point, result_valid && (point_index == $past(point_index) + 6'd1), "lane points broken")

  // the final point carries the top index
  `LPPS_ASSERT_SAME(a_last_index, clk, rst, result_valid && last_point, point_index == 6'(POINT_COUNT - 1), "wrong final index")

  // after a final point a new lane starts at index zero
  `LPPS_ASSERT_NEXT(a_lane_restart, clk, rst, result_valid && last_point, !result_valid || (point_index == 6'd0), "lane does not restart at zero")

endmodule

bind lane_polynomial_point_sampler_unit lpps_checker #(
  .POINT_COUNT (POINT_COUNT)
) u_lpps_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .point_index  (point_index),
  .last_point   (last_point)
);
